[src/rcf_pkg.sv]
// rcf_pkg: types, constants and register indexes of the chunk framer
// no dependencies; used by every module in src
package rcf_pkg;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam int  CFG_ADDR_W  = 5;
    localparam int  CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_LEN     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AUDIO_TYPE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VIDEO_TYPE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AUDIO_CHAN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VIDEO_CHAN    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_CHAN  = 3'd5;

    localparam logic [15:0] CHUNK_LEN_RESET  = 16'd128;
    localparam logic [7:0]  AUDIO_TYPE_RESET = 8'd8;
    localparam logic [7:0]  VIDEO_TYPE_RESET = 8'd9;
    localparam logic [5:0]  AUDIO_CHAN_RESET = 6'd4;
    localparam logic [5:0]  VIDEO_CHAN_RESET = 6'd6;
    localparam logic [5:0]  CMD_CHAN_RESET   = 6'd3;

    localparam logic [23:0] TS_MAX      = 24'hFFFFFF;
    localparam logic [1:0]  FMT3_BITS   = 2'b11;
    localparam logic [1:0]  FMT0_BITS   = 2'b00;

    localparam logic [3:0]  HDR_LAST     = 4'd11;
    localparam logic [3:0]  HDR_EXT_LAST = 4'd15;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [7:0]  msg_type;
        logic [31:0] msg_stream;
        logic [31:0] time_ms;
        logic [23:0] msg_length;
        logic [7:0]  payload_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_end;
    } result_t;

    typedef struct packed {
        logic [15:0] chunk_len;
        logic [7:0]  audio_type_code;
        logic [7:0]  video_type_code;
        logic [5:0]  audio_stream_chan;
        logic [5:0]  video_stream_chan;
        logic [5:0]  command_stream_chan;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  chan;
        logic        ext;
        logic [7:0]  msg_type;
        logic [31:0] msg_stream;
        logic [31:0] time_ms;
        logic [23:0] msg_length;
        logic [7:0]  payload_byte;
        logic        msg_end;
        logic        cont;
    } job_t;

endpackage

[src/rcf_front.sv]
// rcf_front: accepts words, tracks the open message and classifies each word
// depends on rcf_pkg; feeds rcf_queue
module rcf_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  rcf_pkg::cfg_t cfg,
    input  logic          msg_valid,
    input  rcf_pkg::item_t msg_word,
    input  logic          queue_full,
    output logic          msg_stall,
    output logic          push,
    output rcf_pkg::job_t push_job
);

    logic [23:0] bytes_left_reg;
    logic [23:0] bytes_left_next;
    logic [15:0] chunk_fill_reg;
    logic [15:0] chunk_fill_next;
    logic [5:0]  active_chan_reg;
    logic [5:0]  active_chan_next;

    logic        accept;
    logic [5:0]  hdr_chan;
    logic [15:0] limit;
    logic [23:0] left_dec;
    logic [15:0] fill_inc;
    logic        pay_end;
    logic        pay_cont;

    assign msg_stall = queue_full;
    assign accept    = msg_valid && !queue_full;

    always_comb
    begin
        if (msg_word.msg_type == cfg.audio_type_code)
            hdr_chan = cfg.audio_stream_chan;
        else if (msg_word.msg_type == cfg.video_type_code)
            hdr_chan = cfg.video_stream_chan;
        else
            hdr_chan = cfg.command_stream_chan;
    end

    assign limit    = (cfg.chunk_len == 16'd0) ? 16'd1 : cfg.chunk_len;
    assign left_dec = bytes_left_reg - 24'd1;
    assign fill_inc = chunk_fill_reg + 16'd1;
    assign pay_end  = (left_dec == 24'd0);
    assign pay_cont = !pay_end && (fill_inc >= limit);

    always_comb
    begin
        bytes_left_next  = bytes_left_reg;
        chunk_fill_next  = chunk_fill_reg;
        active_chan_next = active_chan_reg;
        push             = 1'b0;
        push_job         = '0;
        push_job.kind         = msg_word.kind;
        push_job.msg_type     = msg_word.msg_type;
        push_job.msg_stream   = msg_word.msg_stream;
        push_job.time_ms      = msg_word.time_ms;
        push_job.msg_length   = msg_word.msg_length;
        push_job.payload_byte = msg_word.payload_byte;
        if (msg_word.kind == rcf_pkg::KIND_HEADER)
        begin
            push_job.chan = hdr_chan;
            push_job.ext  = (msg_word.time_ms >= {8'd0, rcf_pkg::TS_MAX});
            if (accept)
            begin
                push             = 1'b1;
                bytes_left_next  = msg_word.msg_length;
                chunk_fill_next  = 16'd0;
                active_chan_next = hdr_chan;
            end
        end
        else
        begin
            push_job.chan    = active_chan_reg;
            push_job.msg_end = pay_end;
            push_job.cont    = pay_cont;
            if (accept && bytes_left_reg != 24'd0)
            begin
                push            = 1'b1;
                bytes_left_next = left_dec;
                chunk_fill_next = (pay_end || pay_cont) ? 16'd0 : fill_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg  <= '0;
            chunk_fill_reg  <= '0;
            active_chan_reg <= '0;
        end
        else
        begin
            bytes_left_reg  <= bytes_left_next;
            chunk_fill_reg  <= chunk_fill_next;
            active_chan_reg <= active_chan_next;
        end
    end

endmodule

[src/rcf_queue.sv]
// rcf_queue: short job queue between the front and the back
// depends on rcf_pkg
module rcf_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rcf_pkg::job_t push_job,
    input  logic          pop,
    output rcf_pkg::job_t head,
    output logic          full,
    output logic          empty
);

    rcf_pkg::job_t                 entry_reg [rcf_pkg::QDEPTH];
    logic [rcf_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [rcf_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [rcf_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [rcf_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [rcf_pkg::QCOUNT_W-1:0]  count_reg;
    logic [rcf_pkg::QCOUNT_W-1:0]  count_next;

    assign full  = (count_reg == rcf_pkg::QCOUNT_W'(rcf_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/rcf_back.sv]
// rcf_back: expands queued jobs into chunk stream bytes behind an output register
// depends on rcf_pkg; reads rcf_queue
module rcf_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  rcf_pkg::job_t    head,
    input  logic             empty,
    output logic             pop,
    input  logic             chunk_stall,
    output logic             chunk_valid,
    output rcf_pkg::result_t chunk_word
);

    logic [3:0]       idx_reg;
    logic [3:0]       idx_next;
    logic             valid_reg;
    logic             valid_next;
    rcf_pkg::result_t word_reg;
    rcf_pkg::result_t word_next;

    logic             load;
    logic             job_last;
    logic [23:0]      ts;
    logic [7:0]       hdr_byte;

    assign load = !empty && (!valid_reg || !chunk_stall);
    assign ts   = head.ext ? rcf_pkg::TS_MAX : head.time_ms[23:0];

    always_comb
    begin
        case (idx_reg)
            4'd0:    hdr_byte = {rcf_pkg::FMT0_BITS, head.chan};
            4'd1:    hdr_byte = ts[23:16];
            4'd2:    hdr_byte = ts[15:8];
            4'd3:    hdr_byte = ts[7:0];
            4'd4:    hdr_byte = head.msg_length[23:16];
            4'd5:    hdr_byte = head.msg_length[15:8];
            4'd6:    hdr_byte = head.msg_length[7:0];
            4'd7:    hdr_byte = head.msg_type;
            4'd8:    hdr_byte = head.msg_stream[7:0];
            4'd9:    hdr_byte = head.msg_stream[15:8];
            4'd10:   hdr_byte = head.msg_stream[23:16];
            4'd11:   hdr_byte = head.msg_stream[31:24];
            4'd12:   hdr_byte = head.time_ms[31:24];
            4'd13:   hdr_byte = head.time_ms[23:16];
            4'd14:   hdr_byte = head.time_ms[15:8];
            default: hdr_byte = head.time_ms[7:0];
        endcase
    end

    always_comb
    begin
        word_next = word_reg;
        if (head.kind == rcf_pkg::KIND_HEADER)
        begin
            job_last              = (idx_reg == (head.ext ? rcf_pkg::HDR_EXT_LAST
                                                          : rcf_pkg::HDR_LAST));
            word_next.out_byte    = hdr_byte;
            word_next.run_last    = job_last;
            word_next.message_end = 1'b0;
        end
        else if (idx_reg == 4'd0)
        begin
            job_last              = !head.cont;
            word_next.out_byte    = head.payload_byte;
            word_next.run_last    = !head.cont;
            word_next.message_end = head.msg_end;
        end
        else
        begin
            // continuation header after a full chunk
            job_last              = 1'b1;
            word_next.out_byte    = {rcf_pkg::FMT3_BITS, head.chan};
            word_next.run_last    = 1'b1;
            word_next.message_end = 1'b0;
        end
    end

    assign pop = load && job_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = job_last ? 4'd0 : idx_reg + 4'd1;
            valid_next = 1'b1;
        end
        else if (!chunk_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign chunk_valid = valid_reg;
    assign chunk_word  = word_reg;

endmodule

[src/rtmp_chunk_framer.sv]
// rtmp_chunk_framer: top level with the register port, front, queue and back
// depends on rcf_pkg, rcf_front, rcf_queue, rcf_back
//
// Header words (kind 0) open a message and become a 12-byte format-0 chunk
// header, 16 bytes when the timestamp saturates; payload words (kind 1) pass
// one byte each and get a 1-byte format-3 header after each full chunk
// while bytes remain; a payload word with no open message is dropped. The
// front takes one word a cycle, stalling the input only while the queue is
// full, and hands jobs to a four-entry queue; the back sends one byte a
// cycle from its output register while chunk_stall is low, so payload
// streams at one word per cycle when neither stalls, a continuation gives
// two output bytes and a header 12 or 16. Registers lie at byte address 4*i.
module rtmp_chunk_framer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rcf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               msg_valid,
    output logic                               msg_stall,
    input  rcf_pkg::item_t                     msg_word,
    output logic                               chunk_valid,
    input  logic                               chunk_stall,
    output rcf_pkg::result_t                   chunk_word
);

    rcf_pkg::cfg_t cfg_reg;
    rcf_pkg::cfg_t cfg_next;

    logic [rcf_pkg::CFG_INDEX_W-1:0] reg_index;
    logic                            cfg_write;

    logic          push;
    logic          pop;
    logic          queue_full;
    logic          queue_empty;
    rcf_pkg::job_t push_job;
    rcf_pkg::job_t head;

    assign pready    = 1'b1;
    assign reg_index = paddr[rcf_pkg::CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_index)
                rcf_pkg::REG_CHUNK_LEN:    cfg_next.chunk_len           = pwdata[15:0];
                rcf_pkg::REG_AUDIO_TYPE:   cfg_next.audio_type_code     = pwdata[7:0];
                rcf_pkg::REG_VIDEO_TYPE:   cfg_next.video_type_code     = pwdata[7:0];
                rcf_pkg::REG_AUDIO_CHAN:   cfg_next.audio_stream_chan   = pwdata[5:0];
                rcf_pkg::REG_VIDEO_CHAN:   cfg_next.video_stream_chan   = pwdata[5:0];
                rcf_pkg::REG_COMMAND_CHAN: cfg_next.command_stream_chan = pwdata[5:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            rcf_pkg::REG_CHUNK_LEN:    prdata = {16'd0, cfg_reg.chunk_len};
            rcf_pkg::REG_AUDIO_TYPE:   prdata = {24'd0, cfg_reg.audio_type_code};
            rcf_pkg::REG_VIDEO_TYPE:   prdata = {24'd0, cfg_reg.video_type_code};
            rcf_pkg::REG_AUDIO_CHAN:   prdata = {26'd0, cfg_reg.audio_stream_chan};
            rcf_pkg::REG_VIDEO_CHAN:   prdata = {26'd0, cfg_reg.video_stream_chan};
            rcf_pkg::REG_COMMAND_CHAN: prdata = {26'd0, cfg_reg.command_stream_chan};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chunk_len           <= rcf_pkg::CHUNK_LEN_RESET;
            cfg_reg.audio_type_code     <= rcf_pkg::AUDIO_TYPE_RESET;
            cfg_reg.video_type_code     <= rcf_pkg::VIDEO_TYPE_RESET;
            cfg_reg.audio_stream_chan   <= rcf_pkg::AUDIO_CHAN_RESET;
            cfg_reg.video_stream_chan   <= rcf_pkg::VIDEO_CHAN_RESET;
            cfg_reg.command_stream_chan <= rcf_pkg::CMD_CHAN_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    rcf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .msg_valid  (msg_valid),
        .msg_word   (msg_word),
        .queue_full (queue_full),
        .msg_stall  (msg_stall),
        .push       (push),
        .push_job   (push_job)
    );

    rcf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    rcf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (queue_empty),
        .pop         (pop),
        .chunk_stall (chunk_stall),
        .chunk_valid (chunk_valid),
        .chunk_word  (chunk_word)
    );

endmodule

[src/rcf_checker.sv]
// rcf_checker: port-level assertions for rtmp_chunk_framer, bound to the top level
// depends on rcf_pkg and rtmp_chunk_framer
module rcf_checker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pready,
    input  logic             chunk_valid,
    input  logic             chunk_stall,
    input  rcf_pkg::result_t chunk_word
);

    // a held output word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        chunk_valid && chunk_stall |=> chunk_valid && $stable(chunk_word))
        else $error("output word changed while stalled");

    // the final payload byte ends the run of its input word
    assert property (@(posedge clk) disable iff (!rst_n)
        chunk_valid && chunk_word.message_end |-> chunk_word.run_last)
        else $error("message end without run end");

    // nothing comes out right after reset
    assert property (@(posedge clk) $rose(rst_n) |-> !chunk_valid)
        else $error("output valid out of reset");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("register port not ready");

endmodule

bind rtmp_chunk_framer rcf_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .pready      (pready),
    .chunk_valid (chunk_valid),
    .chunk_stall (chunk_stall),
    .chunk_word  (chunk_word)
);
